// ----- hw/rtl/hlsi_pkg.sv -----
// Shared constants, register codes and control structs of the hoist link interlock.
`default_nettype none

package hlsi_pkg;

	localparam int CHAN_W           = 16;
	localparam int MAX_CHANNELS     = 6;
	localparam int NUM_CHANNELS_DEF = 6;
	localparam int TIMER_W          = 16;
	localparam int COUNT_W          = 8;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;

	localparam logic [TIMER_W-1:0] TIMEOUT_TICKS_RST     = 16'd150;
	localparam logic [COUNT_W-1:0] VALID_THRESHOLD_RST   = 8'd5;
	localparam logic [TIMER_W-1:0] CONTROL_PERIOD_RST    = 16'd25;
	localparam logic [TIMER_W-1:0] BLINK_HALF_PERIOD_RST = 16'd500;
	localparam logic [COUNT_W-1:0] BLINK_MASK_RST        = 8'h01;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT_TICKS     = 3'd0,
		REG_VALID_THRESHOLD   = 3'd1,
		REG_CONTROL_PERIOD    = 3'd2,
		REG_BLINK_HALF_PERIOD = 3'd3,
		REG_BLINK_MASK        = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		REQ_MESSAGE = 1'b0,
		REQ_TICK    = 1'b1
	} req_t;

	typedef struct packed {
		logic [TIMER_W-1:0] timeout_ticks;
		logic [COUNT_W-1:0] valid_threshold;
		logic [TIMER_W-1:0] control_period;
		logic [TIMER_W-1:0] blink_half_period;
	} timer_cfg_t;

	typedef struct packed {
		logic msg;
		logic tick;
	} timer_ctrl_t;

	// Values as they stand after the current tick has been applied
	typedef struct packed {
		logic               link_up;
		logic [COUNT_W-1:0] blink_count;
		logic               period_end;
	} timer_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hoist_link_safety_interlock.sv -----
// Top level of the hoist link safety interlock: input stage, command image and result register.
// Usage:
//   Input channel (in_valid / in_stall): each transfer is either a command message
//   (req_type 0, six channel words) or one time tick (req_type 1, estop_loop_ok level).
//   Output channel (out_valid / out_stall): one result per tick that closes a control
//   period; messages and other ticks give nothing.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is always high;
//   write only while no transfer is in flight.
// Timing:
//   An item is captured in the input register and applied from there; the result of a
//   period-ending tick is loaded into the result register as the tick leaves it. One
//   item per cycle is taken for as long as the output is not stalled; the timers and
//   image registers update as each item is applied, which sets that rate.
// Stall:
//   The result register holds while out_stall is high. Messages and ticks that close no
//   period keep flowing; only a period-ending tick waits in the input register, and
//   in_stall rises behind it.
// Reset:
//   arst_n clears the image, the counters and the link (link down, watchdog cleared), and loads
//   the register defaults: timeout 150, threshold 5, period 25, blink 500, mask 1.
`default_nettype none

module hoist_link_safety_interlock #(
	parameter int NUM_CHANNELS = hlsi_pkg::NUM_CHANNELS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,

	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               req_type,
	input  wire  [hlsi_pkg::CHAN_W-1:0]       chan0_word,
	input  wire  [hlsi_pkg::CHAN_W-1:0]       chan1_word,
	input  wire  [hlsi_pkg::CHAN_W-1:0]       chan2_word,
	input  wire  [hlsi_pkg::CHAN_W-1:0]       chan3_word,
	input  wire  [hlsi_pkg::CHAN_W-1:0]       chan4_word,
	input  wire  [hlsi_pkg::CHAN_W-1:0]       chan5_word,
	input  wire                               estop_loop_ok,

	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              contactor_enable,
	output logic                              push_image,
	output logic [hlsi_pkg::CHAN_W-1:0]       out_chan0,
	output logic [hlsi_pkg::CHAN_W-1:0]       out_chan1,
	output logic [hlsi_pkg::CHAN_W-1:0]       out_chan2,
	output logic [hlsi_pkg::CHAN_W-1:0]       out_chan3,
	output logic [hlsi_pkg::CHAN_W-1:0]       out_chan4,
	output logic [hlsi_pkg::CHAN_W-1:0]       out_chan5,
	output logic [hlsi_pkg::MAX_CHANNELS-1:0] go_lamps,
	output logic                              link_lamp,

	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [hlsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [hlsi_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CHW = hlsi_pkg::CHAN_W;
	localparam int MAXC = hlsi_pkg::MAX_CHANNELS;
	localparam int CW = hlsi_pkg::COUNT_W;

	// Configuration registers
	hlsi_pkg::timer_cfg_t tcfg_q;
	logic [CW-1:0]        blink_mask_q;

	// Input stage
	logic                 valid_s1;
	hlsi_pkg::req_t       req_s1;
	logic                 loop_ok_s1;
	logic [CHW-1:0]       chan_s1 [NUM_CHANNELS];
	logic [CHW-1:0]       word_in [MAXC];

	// Command image and the image seen at the last evaluation
	logic [CHW-1:0]       image_q [NUM_CHANNELS];
	logic [CHW-1:0]       prev_q  [NUM_CHANNELS];

	// Result register
	logic                 out_valid_q;
	logic                 contactor_q;
	logic                 push_q;
	logic [CHW-1:0]       out_word_q [MAXC];
	logic [MAXC-1:0]      lamps_q;
	logic                 link_lamp_q;

	hlsi_pkg::timer_ctrl_t tctrl;
	hlsi_pkg::timer_stat_t tstat;

	logic                 is_tick;
	logic                 wants_result;
	logic                 s1_go;
	logic                 fire;
	logic                 eval_now;
	logic [NUM_CHANNELS-1:0] nz;
	logic [NUM_CHANNELS-1:0] df;
	logic [MAXC-1:0]      lamps_d;
	logic [CHW-1:0]       out_word_d [MAXC];
	logic                 blank;
	logic                 lamp_d;

	assign word_in[0] = chan0_word;
	assign word_in[1] = chan1_word;
	assign word_in[2] = chan2_word;
	assign word_in[3] = chan3_word;
	assign word_in[4] = chan4_word;
	assign word_in[5] = chan5_word;

	// Configuration writes go straight into the registers; no backpressure needed
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcfg_q.timeout_ticks     <= hlsi_pkg::TIMEOUT_TICKS_RST;
			tcfg_q.valid_threshold   <= hlsi_pkg::VALID_THRESHOLD_RST;
			tcfg_q.control_period    <= hlsi_pkg::CONTROL_PERIOD_RST;
			tcfg_q.blink_half_period <= hlsi_pkg::BLINK_HALF_PERIOD_RST;
			blink_mask_q             <= hlsi_pkg::BLINK_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hlsi_pkg::REG_TIMEOUT_TICKS:     tcfg_q.timeout_ticks     <= cfg_data;
				hlsi_pkg::REG_VALID_THRESHOLD:   tcfg_q.valid_threshold   <= cfg_data[CW-1:0];
				hlsi_pkg::REG_CONTROL_PERIOD:    tcfg_q.control_period    <= cfg_data;
				hlsi_pkg::REG_BLINK_HALF_PERIOD: tcfg_q.blink_half_period <= cfg_data;
				hlsi_pkg::REG_BLINK_MASK:        blink_mask_q             <= cfg_data[CW-1:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// Stage control: only a period-ending tick can be held back by a full,
	// stalled result register.
	assign is_tick      = (req_s1 == hlsi_pkg::REQ_TICK);
	assign wants_result = is_tick && tstat.period_end;
	assign s1_go        = !wants_result || !out_valid_q || !out_stall;
	assign fire         = valid_s1 && s1_go;
	assign eval_now     = fire && wants_result;
	assign in_stall     = valid_s1 && !s1_go;

	assign tctrl.msg  = fire && !is_tick;
	assign tctrl.tick = fire && is_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1     <= hlsi_pkg::req_t'(req_type);
			loop_ok_s1 <= estop_loop_ok;
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				chan_s1[k] <= word_in[k];
			end
		end
	end

	hlsi_timers u_timers (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (tcfg_q),
		.ctrl   (tctrl),
		.stat   (tstat)
	);

	// Store the image on a message; remember it on every evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				image_q[k] <= '0;
				prev_q[k]  <= '0;
			end
		end else begin
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				if (tctrl.msg) begin
					image_q[k] <= chan_s1[k];
				end
				if (eval_now) begin
					prev_q[k] <= image_q[k];
				end
			end
		end
	end

	// Per-channel flags; channels past NUM_CHANNELS read as zero
	for (genvar k = 0; k < MAXC; k++) begin : g_chan
		if (k < NUM_CHANNELS) begin : g_used
			assign nz[k]               = (image_q[k] != '0);
			assign df[k]               = (image_q[k] != prev_q[k]);
			assign lamps_d[MAXC-1-k]   = nz[k];
			assign out_word_d[k]       = blank ? '0 : image_q[k];
		end else begin : g_unused
			assign lamps_d[MAXC-1-k]   = 1'b0;
			assign out_word_d[k]       = '0;
		end
	end

	// Blank on link loss, emergency or an all-zero image
	assign blank  = !tstat.link_up || !loop_ok_s1 || !(|nz);
	assign lamp_d = tstat.link_up && (loop_ok_s1 || ((tstat.blink_count & blink_mask_q) != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eval_now) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_now) begin
			contactor_q <= !blank;
			push_q      <= blank || (|df);
			lamps_q     <= blank ? '0 : lamps_d;
			link_lamp_q <= lamp_d;
			for (int k = 0; k < MAXC; k++) begin
				out_word_q[k] <= out_word_d[k];
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign contactor_enable = contactor_q;
	assign push_image       = push_q;
	assign out_chan0        = out_word_q[0];
	assign out_chan1        = out_word_q[1];
	assign out_chan2        = out_word_q[2];
	assign out_chan3        = out_word_q[3];
	assign out_chan4        = out_word_q[4];
	assign out_chan5        = out_word_q[5];
	assign go_lamps         = lamps_q;
	assign link_lamp        = link_lamp_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		eval_now |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_enable_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && contactor_q) |-> link_lamp_q)
		else $error("contactors enabled with link lamp dark");

	a_enable_image: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && contactor_q) |-> (lamps_q != '0))
		else $error("contactors enabled on an empty image");

	a_blank_push: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !contactor_q) |-> (push_q && lamps_q == '0))
		else $error("blanked result not pushed as zero image");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/hlsi_timers.sv -----
// Link watchdog, message counter, blink prescaler and control period timer.
`default_nettype none

module hlsi_timers (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire hlsi_pkg::timer_cfg_t  cfg,
	input  wire hlsi_pkg::timer_ctrl_t ctrl,
	output hlsi_pkg::timer_stat_t stat
);

	localparam int TW = hlsi_pkg::TIMER_W;
	localparam int CW = hlsi_pkg::COUNT_W;

	logic          link_q;
	logic [TW-1:0] wd_q;
	logic [CW-1:0] valid_cnt_q;
	logic [CW-1:0] blink_q;
	logic [TW-1:0] prescale_q;
	logic [TW-1:0] period_q;

	logic [TW-1:0] wd_inc;
	logic [TW-1:0] prescale_inc;
	logic [TW-1:0] period_inc;
	logic          expire;
	logic          blink_step;
	logic          period_end;

	always_comb begin
		// saturate the watchdog count at all ones
		wd_inc       = (wd_q == '1) ? wd_q : TW'(wd_q + 1'b1);
		expire       = link_q && (wd_inc >= cfg.timeout_ticks);
		prescale_inc = TW'(prescale_q + 1'b1);
		blink_step   = (prescale_inc >= cfg.blink_half_period);
		period_inc   = TW'(period_q + 1'b1);
		period_end   = (period_inc >= cfg.control_period);

		stat.link_up     = link_q && !expire;
		stat.blink_count = blink_step ? CW'(blink_q + 1'b1) : blink_q;
		stat.period_end  = period_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q      <= 1'b0;
			wd_q        <= '0;
			valid_cnt_q <= '0;
			blink_q     <= '0;
			prescale_q  <= '0;
			period_q    <= '0;
		end else if (ctrl.tick) begin
			if (expire) begin
				link_q      <= 1'b0;
				wd_q        <= '0;
				valid_cnt_q <= '0;
			end else if (link_q) begin
				wd_q <= wd_inc;
			end
			prescale_q <= blink_step ? '0 : prescale_inc;
			blink_q    <= stat.blink_count;
			period_q   <= period_end ? '0 : period_inc;
		end else if (ctrl.msg) begin
			if (valid_cnt_q < cfg.valid_threshold) begin
				valid_cnt_q <= CW'(valid_cnt_q + 1'b1);
			end else begin
				// rearm the one-shot watchdog and raise the link
				link_q <= 1'b1;
				wd_q   <= '0;
			end
		end
	end

endmodule

`default_nettype wire
